@@ sv/ppe_pkg.sv @@
// Package for the particle pool engine: codes, shared structs and helper functions.
// No dependencies; imported by ppe_alu, ppe_store, the top level and the testbench.
package ppe_pkg;

    localparam int POOL_SIZE_DEF = 32;
    localparam int SLOT_W = 6;

    localparam logic [1:0] KIND_EMIT   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic [30:0] life_total;
        logic [31:0] life_left;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] size_pair;
        logic [63:0] color_pair;
    } ppe_entry_t;

    typedef struct packed {
        logic       en_all;
        logic       en_x;
        logic       en_yl;
        ppe_entry_t data;
    } st_wr_t;

    // saturate to 32-bit signed
    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        logic [31:0] r;
        begin
            if (v > SAT_HI)
                r = 32'h7FFF_FFFF;
            else if (v < SAT_LO)
                r = 32'h8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // {final, start} of one interpolated channel: 0 size, 1..4 color bytes
    function automatic logic [31:0] chan_pair(input logic [2:0] ch,
                                              input logic [31:0] sp,
                                              input logic [63:0] cp);
        logic [31:0] r;
        begin
            case (ch)
                3'd0: r = {sp[31:16], sp[15:0]};
                3'd1: r = {8'd0, cp[39:32], 8'd0, cp[7:0]};
                3'd2: r = {8'd0, cp[47:40], 8'd0, cp[15:8]};
                3'd3: r = {8'd0, cp[55:48], 8'd0, cp[23:16]};
                3'd4: r = {8'd0, cp[63:56], 8'd0, cp[31:24]};
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ sv/ppe_in_if.sv @@
// Input channel of the particle pool engine: valid/ready plus item payload.
// No dependencies.
interface ppe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [30:0] life_total;
    logic [15:0] size_start;
    logic [15:0] size_final;
    logic [31:0] color_start;
    logic [31:0] color_final;
    logic [30:0] time_step;

    modport source (output valid, kind, pos_x, pos_y, vel_x, vel_y, life_total,
                    size_start, size_final, color_start, color_final, time_step,
                    input ready);
    modport sink   (input valid, kind, pos_x, pos_y, vel_x, vel_y, life_total,
                    size_start, size_final, color_start, color_final, time_step,
                    output ready);
endinterface

@@ sv/ppe_out_if.sv @@
// Result channel of the particle pool engine: valid/ready plus sprite payload.
// No dependencies.
interface ppe_out_if;
    logic        valid;
    logic        ready;
    logic        sprite_valid;
    logic [5:0]  slot;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [15:0] out_size;
    logic [31:0] out_color;
    logic        last;

    modport source (output valid, sprite_valid, slot, out_x, out_y, out_size,
                    out_color, last, input ready);
    modport sink   (input valid, sprite_valid, slot, out_x, out_y, out_size,
                    out_color, last, output ready);
endinterface

@@ sv/ppe_alu.sv @@
// Shared arithmetic unit: signed 32x32 multiply or one restoring divide step.
// Depends on ppe_pkg.
module ppe_alu (
    input  logic              clk,
    input  ppe_pkg::alu_cmd_t cmd,
    output logic [63:0]       res
);
    import ppe_pkg::*;

    logic [32:0] rem2;
    logic [32:0] rem_sub;
    logic        q_bit;

    assign rem2    = {cmd.a, 1'b0};
    assign rem_sub = rem2 - {1'b0, cmd.b};
    assign q_bit   = (rem2 >= {1'b0, cmd.b});

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ALU_MUL: res <= $signed(cmd.a) * $signed(cmd.b);
            ALU_DIV: res <= {31'd0, q_bit, (q_bit ? rem_sub[31:0] : rem2[31:0])};
            default: res <= 64'd0;
        endcase
    end
endmodule

@@ sv/ppe_store.sv @@
// Particle store: one memory per particle field, one write and one read port.
// Depends on ppe_pkg.
module ppe_store #(
    parameter int POOL_SIZE = ppe_pkg::POOL_SIZE_DEF,
    parameter int IDX_W     = 5
) (
    input  logic                clk,
    input  logic [IDX_W-1:0]    waddr,
    input  ppe_pkg::st_wr_t     wr,
    input  logic [IDX_W-1:0]    raddr,
    output ppe_pkg::ppe_entry_t rd
);
    import ppe_pkg::*;

    logic [30:0] life_total_mem [POOL_SIZE];
    logic [31:0] life_left_mem  [POOL_SIZE];
    logic [31:0] pos_x_mem      [POOL_SIZE];
    logic [31:0] pos_y_mem      [POOL_SIZE];
    logic [31:0] vel_x_mem      [POOL_SIZE];
    logic [31:0] vel_y_mem      [POOL_SIZE];
    logic [31:0] size_mem       [POOL_SIZE];
    logic [63:0] color_mem      [POOL_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.en_all)
        begin
            life_total_mem[waddr] <= wr.data.life_total;
            vel_x_mem[waddr]      <= wr.data.vel_x;
            vel_y_mem[waddr]      <= wr.data.vel_y;
            size_mem[waddr]       <= wr.data.size_pair;
            color_mem[waddr]      <= wr.data.color_pair;
        end
        if (wr.en_all || wr.en_x)
            pos_x_mem[waddr] <= wr.data.pos_x;
        if (wr.en_all || wr.en_yl)
        begin
            pos_y_mem[waddr]     <= wr.data.pos_y;
            life_left_mem[waddr] <= wr.data.life_left;
        end
    end

    always_ff @(posedge clk)
    begin
        rd.life_total <= life_total_mem[raddr];
        rd.life_left  <= life_left_mem[raddr];
        rd.pos_x      <= pos_x_mem[raddr];
        rd.pos_y      <= pos_y_mem[raddr];
        rd.vel_x      <= vel_x_mem[raddr];
        rd.vel_y      <= vel_y_mem[raddr];
        rd.size_pair  <= size_mem[raddr];
        rd.color_pair <= color_mem[raddr];
    end
endmodule

@@ sv/particle_pool_engine_core.sv @@
// Particle pool engine top level: sequencer around the shared ALU and the particle store.
// Depends on ppe_pkg, ppe_in_if, ppe_out_if, ppe_alu, ppe_store.
//
// Usage: items arrive on cmd (valid/ready); results leave on rsp (valid/ready).
// kind emit writes one particle at the ring index and returns one ack (last=1,
// slot = slot written). kind tick ages and moves every active particle that has life
// left, retires the others and returns one ack. kind render returns one sprite per
// active particle in slot order (last=0), then a marker (sprite_valid=0, last=1). kind 3
// returns one all-zero result with last=1.
// cmd.ready is high only while the sequencer is idle; one item at a time.
// Steps: an emit goes from idle to the final state, which loads the ack into the
// output register. Tick: scan per free slot; scan, store read, x multiply, y multiply
// per active slot; scan and store read for a slot that retires. Render: scan per free
// slot; per active slot scan, store read, 16 divide steps for the life fraction, size
// setup plus 5 mix steps for size and the four color bytes, sprite transfer; no divide
// runs when the fraction is 0 or 1. All on the one shared multiply/divide unit.
// A walk closes with an end check and a final transfer.
// When rsp stalls, the sequencer holds in place with the pending result in the
// output register; nothing is dropped.
// Reset clears the active flags, the ring index and the output valid; the
// store contents are not cleared and are only read for active slots.
module particle_pool_engine_core #(
    parameter int POOL_SIZE = ppe_pkg::POOL_SIZE_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    ppe_in_if.sink    cmd,
    ppe_out_if.source rsp
);
    import ppe_pkg::*;

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam logic [CNT_W-1:0] IDX_END = CNT_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_TX,
        S_TY,
        S_DIV,
        S_MIXS,
        S_MIX,
        S_SPR,
        S_FIN
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [POOL_SIZE-1:0] active_reg;
    logic [1:0]        kind_reg;
    logic [30:0]       ts_reg;
    logic [5:0]        ack_slot_reg;
    logic [3:0]        cnt_reg;
    logic [15:0]       q_reg;
    logic [16:0]       f_reg;
    logic [2:0]        ch_reg;
    logic [15:0]       size_reg;
    logic [31:0]       color_reg;

    logic              out_valid_reg;
    logic              out_sprite_reg;
    logic [5:0]        out_slot_reg;
    logic [31:0]       out_x_reg;
    logic [31:0]       out_y_reg;
    logic [15:0]       out_size_reg;
    logic [31:0]       out_color_reg;
    logic              out_last_reg;

    alu_cmd_t          alu_cmd;
    logic [63:0]       alu_res;
    st_wr_t            st_wr;
    ppe_entry_t        rd;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  cur;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [31:0]       pos_sel;
    logic [31:0]       new_pos;
    logic [31:0]       new_life;
    logic [2:0]        ch_iss;
    logic [2:0]        ch_col;
    logic [31:0]       pair_iss;
    logic [31:0]       pair_col;
    logic signed [16:0] mix_diff;
    logic signed [39:0] mix_sum;
    logic [15:0]       mixed;
    logic              left_pos;
    logic              div_bit;

    ppe_alu u_alu (
        .clk (clk),
        .cmd (alu_cmd),
        .res (alu_res)
    );

    ppe_store #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk   (clk),
        .waddr (waddr),
        .wr    (st_wr),
        .raddr (cur),
        .rd    (rd)
    );

    assign cur      = idx_reg[IDX_W-1:0];
    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    // output register takes a new result this cycle
    assign out_load = ((state_reg == S_SPR) || (state_reg == S_FIN)) && out_free;
    assign left_pos = !rd.life_left[31] && (rd.life_left != 32'd0);
    assign div_bit  = alu_res[32];

    // tick arithmetic: position plus floor(velocity * step), life minus step
    assign pos_sel  = (state_reg == S_TY) ? rd.pos_y : rd.pos_x;
    assign new_pos  = sat32(49'($signed(pos_sel)) + 49'($signed(alu_res[63:16])));
    assign new_life = sat32(49'($signed(rd.life_left)) - 49'($signed({1'b0, ts_reg})));

    // interpolation: final*2^16 + (start - final)*f, then drop 16 fraction bits
    assign ch_iss   = (state_reg == S_MIXS) ? 3'd0 : ch_reg;
    assign ch_col   = ch_reg - 3'd1;
    assign pair_iss = chan_pair(ch_iss, rd.size_pair, rd.color_pair);
    assign pair_col = chan_pair(ch_col, rd.size_pair, rd.color_pair);
    assign mix_diff = $signed({1'b0, pair_iss[15:0]}) - $signed({1'b0, pair_iss[31:16]});
    assign mix_sum  = $signed({8'd0, pair_col[31:16], 16'd0}) + $signed(alu_res[39:0]);
    assign mixed    = mix_sum[31:16];

    always_comb
    begin
        alu_cmd.op = ALU_MUL;
        alu_cmd.a  = 32'd0;
        alu_cmd.b  = 32'd0;
        case (state_reg)
            S_LOAD:
            begin
                if (kind_reg == KIND_TICK)
                begin
                    alu_cmd.a = rd.vel_x;
                    alu_cmd.b = {1'b0, ts_reg};
                end
                else
                begin
                    alu_cmd.op = ALU_DIV;
                    alu_cmd.a  = rd.life_left;
                    alu_cmd.b  = {1'b0, rd.life_total};
                end
            end
            S_TX:
            begin
                alu_cmd.a = rd.vel_y;
                alu_cmd.b = {1'b0, ts_reg};
            end
            S_DIV:
            begin
                alu_cmd.op = ALU_DIV;
                alu_cmd.a  = alu_res[31:0];
                alu_cmd.b  = {1'b0, rd.life_total};
            end
            S_MIXS, S_MIX:
            begin
                alu_cmd.a = 32'(mix_diff);
                alu_cmd.b = {15'd0, f_reg};
            end
            default:
            begin
                alu_cmd.op = ALU_MUL;
            end
        endcase
    end

    // store writes: whole entry on emit, x then y/life during a tick
    always_comb
    begin
        waddr                  = (state_reg == S_IDLE) ? wr_idx_reg : cur;
        st_wr.en_all           = (state_reg == S_IDLE) && accept && (cmd.kind == KIND_EMIT);
        st_wr.en_x             = (state_reg == S_TX);
        st_wr.en_yl            = (state_reg == S_TY);
        st_wr.data.life_total  = cmd.life_total;
        st_wr.data.life_left   = st_wr.en_all ? {1'b0, cmd.life_total} : new_life;
        st_wr.data.pos_x       = st_wr.en_all ? cmd.pos_x : new_pos;
        st_wr.data.pos_y       = st_wr.en_all ? cmd.pos_y : new_pos;
        st_wr.data.vel_x       = cmd.vel_x;
        st_wr.data.vel_y       = cmd.vel_y;
        st_wr.data.size_pair   = {cmd.size_final, cmd.size_start};
        st_wr.data.color_pair  = {cmd.color_final, cmd.color_start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            wr_idx_reg     <= '0;
            active_reg     <= '0;
            kind_reg       <= KIND_EMIT;
            ts_reg         <= '0;
            ack_slot_reg   <= '0;
            cnt_reg        <= '0;
            q_reg          <= '0;
            f_reg          <= '0;
            ch_reg         <= '0;
            size_reg       <= '0;
            color_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_sprite_reg <= 1'b0;
            out_slot_reg   <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_size_reg   <= '0;
            out_color_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg     <= cmd.kind;
                        ts_reg       <= cmd.time_step;
                        idx_reg      <= '0;
                        ack_slot_reg <= (cmd.kind == KIND_EMIT) ? SLOT_W'(wr_idx_reg) : '0;
                        case (cmd.kind)
                            KIND_EMIT:
                            begin
                                active_reg[wr_idx_reg] <= 1'b1;
                                wr_idx_reg <= (wr_idx_reg == IDX_LAST) ? '0
                                                                       : wr_idx_reg + 1'b1;
                                state_reg <= S_FIN;
                            end
                            KIND_TICK, KIND_RENDER:
                                state_reg <= S_SCAN;
                            default:
                                state_reg <= S_FIN;
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (idx_reg == IDX_END)
                        state_reg <= S_FIN;
                    else if (active_reg[cur])
                        state_reg <= S_LOAD;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end

                S_LOAD:
                begin
                    if (kind_reg == KIND_TICK)
                    begin
                        if (!left_pos)
                        begin
                            active_reg[cur] <= 1'b0;
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                        else
                            state_reg <= S_TX;
                    end
                    else if (!left_pos)
                    begin
                        f_reg     <= 17'd0;
                        state_reg <= S_MIXS;
                    end
                    else if (rd.life_total == 31'd0 || rd.life_left >= {1'b0, rd.life_total})
                    begin
                        f_reg     <= 17'h10000;
                        state_reg <= S_MIXS;
                    end
                    else
                    begin
                        cnt_reg   <= 4'd15;
                        state_reg <= S_DIV;
                    end
                end

                S_TX:
                    state_reg <= S_TY;

                S_TY:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN;
                end

                S_DIV:
                begin
                    q_reg <= {q_reg[14:0], div_bit};
                    if (cnt_reg == 4'd0)
                    begin
                        f_reg     <= {1'b0, q_reg[14:0], div_bit};
                        state_reg <= S_MIXS;
                    end
                    else
                        cnt_reg <= cnt_reg - 4'd1;
                end

                S_MIXS:
                begin
                    ch_reg    <= 3'd1;
                    state_reg <= S_MIX;
                end

                S_MIX:
                begin
                    case (ch_col)
                        3'd0: size_reg <= mixed;
                        3'd1: color_reg[7:0]   <= mixed[7:0];
                        3'd2: color_reg[15:8]  <= mixed[7:0];
                        3'd3: color_reg[23:16] <= mixed[7:0];
                        default: color_reg[31:24] <= mixed[7:0];
                    endcase
                    if (ch_reg == 3'd5)
                        state_reg <= S_SPR;
                    else
                        ch_reg <= ch_reg + 3'd1;
                end

                S_SPR:
                begin
                    if (out_free)
                    begin
                        out_sprite_reg <= 1'b1;
                        out_slot_reg   <= SLOT_W'(idx_reg);
                        out_x_reg      <= rd.pos_x;
                        out_y_reg      <= rd.pos_y;
                        out_size_reg   <= size_reg;
                        out_color_reg  <= color_reg;
                        out_last_reg   <= 1'b0;
                        idx_reg        <= idx_reg + 1'b1;
                        state_reg      <= S_SCAN;
                    end
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_sprite_reg <= 1'b0;
                        out_slot_reg   <= ack_slot_reg;
                        out_x_reg      <= '0;
                        out_y_reg      <= '0;
                        out_size_reg   <= '0;
                        out_color_reg  <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign cmd.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.sprite_valid = out_sprite_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.out_x        = out_x_reg;
    assign rsp.out_y        = out_y_reg;
    assign rsp.out_size     = out_size_reg;
    assign rsp.out_color    = out_color_reg;
    assign rsp.last         = out_last_reg;
endmodule

@@ sv/ppe_checker.sv @@
// Port-level checks for the particle pool engine, bound to the top level.
// Depends on particle_pool_engine_core.
module ppe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_sprite_valid,
    input logic [31:0] rsp_out_x,
    input logic [15:0] rsp_out_size,
    input logic [31:0] rsp_out_color,
    input logic        rsp_last
);
    // a pending result is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one item at a time: no transfer right after an accepted item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("input taken while busy");

    a_sprite_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_sprite_valid |-> !rsp_last)
        else $error("sprite marked last");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_sprite_valid |->
            rsp_last && rsp_out_x == 32'd0 && rsp_out_size == 16'd0 &&
            rsp_out_color == 32'd0)
        else $error("non-sprite result carries data");
endmodule

bind particle_pool_engine_core ppe_checker u_ppe_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_sprite_valid (rsp.sprite_valid),
    .rsp_out_x        (rsp.out_x),
    .rsp_out_size     (rsp.out_size),
    .rsp_out_color    (rsp.out_color),
    .rsp_last         (rsp.last)
);

@@ dv/tb.sv @@
// Testbench for particle_pool_engine_core: directed table, then random emit/tick/render traffic.
// Depends on ppe_pkg, ppe_in_if, ppe_out_if and the core RTL; self-checking via a pool predictor.
`timescale 1ns / 100ps

module tb;
    import ppe_pkg::*;

    localparam int POOL = POOL_SIZE_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One command item as driven on cmd
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [30:0] life_total;
        logic [15:0] size_start;
        logic [15:0] size_final;
        logic [31:0] color_start;
        logic [31:0] color_final;
        logic [30:0] time_step;
    } cmd_item_t;

    // One result as seen on rsp
    typedef struct {
        logic        sprite_valid;
        logic [5:0]  slot;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [15:0] out_size;
        logic [31:0] out_color;
        logic        last;
    } sprite_t;

    logic clk;
    logic rst_n;

    ppe_in_if  cmd_if ();
    ppe_out_if rsp_if ();

    particle_pool_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Predictor copy of the pool
    bit          pool_active [POOL];
    int          pool_total  [POOL];
    int          pool_left   [POOL];
    int          pool_px     [POOL];
    int          pool_py     [POOL];
    int          pool_vx     [POOL];
    int          pool_vy     [POOL];
    logic [31:0] pool_size   [POOL];
    logic [63:0] pool_color  [POOL];
    int          ring_idx;

    sprite_t sprite_q[$];   // results still owed by the core
    int      n_errors;
    int      n_items;
    int      n_sprites;
    int      n_results;
    int      burst_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int sat_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    // (fin*(1-f) + start*f) >> 16, f in Q1.16
    function automatic logic [31:0] blend(input logic [31:0] fin, input logic [31:0] start,
                                          input logic [16:0] f);
        longint unsigned acc;
        acc = longint'(fin) * (64'd65536 - f) + longint'(start) * f;
        return acc[47:16];
    endfunction

    function automatic sprite_t ack(input logic [5:0] slot);
        sprite_t r;
        r = '{1'b0, slot, 32'd0, 32'd0, 16'd0, 32'd0, 1'b1};
        return r;
    endfunction

    // Apply one accepted item to the pool copy and queue what the core owes for it
    function automatic void advance_pool(input cmd_item_t it);
        longint      ts;
        longint      step;
        logic [16:0] frac;
        longint unsigned q;
        logic [31:0] color;
        sprite_t     r;
        case (it.kind)
            KIND_EMIT:
            begin
                pool_active[ring_idx] = 1'b1;
                pool_total[ring_idx]  = int'({1'b0, it.life_total});
                pool_left[ring_idx]   = int'({1'b0, it.life_total});
                pool_px[ring_idx]     = it.pos_x;
                pool_py[ring_idx]     = it.pos_y;
                pool_vx[ring_idx]     = it.vel_x;
                pool_vy[ring_idx]     = it.vel_y;
                pool_size[ring_idx]   = {it.size_final, it.size_start};
                pool_color[ring_idx]  = {it.color_final, it.color_start};
                sprite_q.push_back(ack(6'(ring_idx)));
                ring_idx = (ring_idx + 1 >= POOL) ? 0 : ring_idx + 1;
            end
            KIND_TICK:
            begin
                ts = longint'({33'd0, it.time_step});
                for (int i = 0; i < POOL; i++)
                begin
                    if (!pool_active[i])
                        continue;
                    if (pool_left[i] <= 0)
                    begin
                        pool_active[i] = 1'b0;
                        continue;
                    end
                    pool_left[i] = sat_q16(longint'(pool_left[i]) - ts);
                    // floor toward minus infinity == arithmetic shift
                    step = (longint'(pool_vx[i]) * ts) >>> 16;
                    pool_px[i] = sat_q16(longint'(pool_px[i]) + step);
                    step = (longint'(pool_vy[i]) * ts) >>> 16;
                    pool_py[i] = sat_q16(longint'(pool_py[i]) + step);
                end
                sprite_q.push_back(ack(6'd0));
            end
            KIND_RENDER:
            begin
                for (int i = 0; i < POOL; i++)
                begin
                    if (!pool_active[i])
                        continue;
                    if (pool_left[i] <= 0)
                        frac = 17'd0;
                    else if (pool_total[i] <= 0)
                        frac = 17'd65536;
                    else
                    begin
                        q = (longint'(unsigned'(pool_left[i])) << 16)
                            / longint'(unsigned'(pool_total[i]));
                        frac = (q > 65536) ? 17'd65536 : 17'(q);
                    end
                    for (int ch = 0; ch < 4; ch++)
                        color[ch*8 +: 8] = 8'(blend(32'(pool_color[i][32 + ch*8 +: 8]),
                                                    32'(pool_color[i][ch*8 +: 8]), frac));
                    r.sprite_valid = 1'b1;
                    r.slot         = 6'(i);
                    r.out_x        = pool_px[i];
                    r.out_y        = pool_py[i];
                    r.out_size     = 16'(blend(32'(pool_size[i][31:16]),
                                               32'(pool_size[i][15:0]), frac));
                    r.out_color    = color;
                    r.last         = 1'b0;
                    sprite_q.push_back(r);
                end
                sprite_q.push_back(ack(6'd0));
            end
            default:
                sprite_q.push_back(ack(6'd0));
        endcase
    endfunction

    function automatic cmd_item_t emit_item(input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] vx, input logic [31:0] vy,
                                            input logic [30:0] life,
                                            input logic [15:0] ss, input logic [15:0] sf,
                                            input logic [31:0] cs, input logic [31:0] cf);
        cmd_item_t it;
        it = '{KIND_EMIT, px, py, vx, vy, life, ss, sf, cs, cf, 31'd0};
        return it;
    endfunction

    function automatic cmd_item_t ctl_item(input logic [1:0] kind, input logic [30:0] ts);
        cmd_item_t it;
        it = '{kind, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 16'd0, 16'd0, 32'd0, 32'd0, ts};
        return it;
    endfunction

    function automatic cmd_item_t random_item();
        cmd_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        it.kind = (pick < 50) ? KIND_EMIT : (pick < 75) ? KIND_TICK :
                  (pick < 94) ? KIND_RENDER : KIND_UNUSED;
        // mostly moderate motion so particles survive a few ticks; some full range
        if ($urandom_range(0, 9) < 8)
        begin
            it.pos_x = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            it.pos_y = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            it.vel_x = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            it.vel_y = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        end
        else
        begin
            it.pos_x = $urandom;
            it.pos_y = $urandom;
            it.vel_x = $urandom;
            it.vel_y = $urandom;
        end
        pick = $urandom_range(0, 19);
        it.life_total  = (pick < 16) ? 31'($urandom_range(32'h1000, 32'h8_0000)) :
                         (pick < 19) ? 31'($urandom) : 31'd0;
        it.size_start  = $urandom;
        it.size_final  = $urandom;
        it.color_start = $urandom;
        it.color_final = $urandom;
        it.time_step   = ($urandom_range(0, 9) < 8) ? 31'($urandom_range(0, 32'h2_0000))
                                                    : 31'($urandom);
        return it;
    endfunction

    // Drive one item from a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input cmd_item_t it);
        if (burst_left == 0)
        begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(0, 8))
                @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        cmd_if.kind        = it.kind;
        cmd_if.pos_x       = it.pos_x;
        cmd_if.pos_y       = it.pos_y;
        cmd_if.vel_x       = it.vel_x;
        cmd_if.vel_y       = it.vel_y;
        cmd_if.life_total  = it.life_total;
        cmd_if.size_start  = it.size_start;
        cmd_if.size_final  = it.size_final;
        cmd_if.color_start = it.color_start;
        cmd_if.color_final = it.color_final;
        cmd_if.time_step   = it.time_step;
        cmd_if.valid       = 1'b1;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        advance_pool(it);
        n_items++;
        burst_left--;
        @(negedge clk);
    endtask

    // Receiver: alternates between no stall, light random stall and long stalls
    int stall_mode;
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            0: rsp_if.ready = 1'b1;
            1: rsp_if.ready = ($urandom_range(0, 9) < 7);
            default: rsp_if.ready = ($urandom_range(0, 9) == 0);
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        sprite_t e;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            n_results++;
            if (rsp_if.sprite_valid)
                n_sprites++;
            if (sprite_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result slot=%0d last=%0b", $time,
                         rsp_if.slot, rsp_if.last);
            end
            else
            begin
                e = sprite_q.pop_front();
                if (rsp_if.sprite_valid !== e.sprite_valid || rsp_if.slot !== e.slot ||
                    rsp_if.out_x !== e.out_x || rsp_if.out_y !== e.out_y ||
                    rsp_if.out_size !== e.out_size || rsp_if.out_color !== e.out_color ||
                    rsp_if.last !== e.last)
                begin
                    n_errors++;
                    $display("%0t: mismatch expected sv=%0b slot=%0d x=%h y=%h ",
                             $time, e.sprite_valid, e.slot, e.out_x, e.out_y,
                             "size=%h color=%h last=%0b",
                             e.out_size, e.out_color, e.last);
                    $display("%0t:          actual   sv=%0b slot=%0d x=%h y=%h ",
                             $time, rsp_if.sprite_valid, rsp_if.slot, rsp_if.out_x,
                             rsp_if.out_y, "size=%h color=%h last=%0b",
                             rsp_if.out_size, rsp_if.out_color, rsp_if.last);
                end
            end
        end
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    cmd_item_t dir_tab   [$];
    bit        dir_typed [$];
    sprite_t   dir_exp   [$];

    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.kind = KIND_EMIT;
        {cmd_if.pos_x, cmd_if.pos_y, cmd_if.vel_x, cmd_if.vel_y} = '0;
        {cmd_if.life_total, cmd_if.size_start, cmd_if.size_final} = '0;
        {cmd_if.color_start, cmd_if.color_final, cmd_if.time_step} = '0;
        n_errors = 0;
        n_items = 0;
        n_sprites = 0;
        n_results = 0;
        burst_left = 0;
        ring_idx = 0;
        foreach (pool_active[i])
            pool_active[i] = 1'b0;
        rst_n = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: typed expectation where obvious, predictor otherwise
        // render of an empty pool: marker only
        dir_tab.push_back(ctl_item(KIND_RENDER, 31'd0));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        // unused kind: all-zero result
        dir_tab.push_back(ctl_item(KIND_UNUSED, 31'h7FFF_FFFF));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        // field extremes, one way round
        dir_tab.push_back(emit_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 16'h0000,
                                    32'hFFFF_FFFF, 32'h0000_0000));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        // and the other way round, shortest nonzero life
        dir_tab.push_back(emit_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 31'd1, 16'h0000, 16'hFFFF,
                                    32'h0000_0000, 32'hFFFF_FFFF));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd1));
        // zero lifetime: fraction 0, retired at the first tick
        dir_tab.push_back(emit_item(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                                    32'hFFFF_8000, 31'd0, 16'h1234, 16'h5678,
                                    32'h1122_3344, 32'h5566_7788));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd2));
        // ordinary particle with negative velocity
        dir_tab.push_back(emit_item(32'h0010_0000, 32'h0020_0000, 32'hFFFF_4000,
                                    32'h0000_C000, 31'h0004_0000, 16'h0100, 16'h0800,
                                    32'hFF80_4010, 32'h00FF_20A0));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd3));
        dir_tab.push_back(ctl_item(KIND_RENDER, 31'd0));
        dir_typed.push_back(0); dir_exp.push_back(ack(6'd0));
        // largest step: life underflow and position saturation both ways
        dir_tab.push_back(ctl_item(KIND_TICK, 31'h7FFF_FFFF));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(ctl_item(KIND_RENDER, 31'd0));
        dir_typed.push_back(0); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(ctl_item(KIND_TICK, 31'd0));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(emit_item(32'hFFF0_0000, 32'h0000_1234, 32'h0003_0000,
                                    32'hFFFD_0000, 31'h0002_0000, 16'hFFFF, 16'hFFFF,
                                    32'h8040_2010, 32'h0102_0408));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd4));
        dir_tab.push_back(ctl_item(KIND_TICK, 31'h0001_0000));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(ctl_item(KIND_RENDER, 31'd0));
        dir_typed.push_back(0); dir_exp.push_back(ack(6'd0));
        // overshoot: negative life left gives fraction 0
        dir_tab.push_back(ctl_item(KIND_TICK, 31'h0003_0000));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(ctl_item(KIND_RENDER, 31'd0));
        dir_typed.push_back(0); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(ctl_item(KIND_TICK, 31'h0000_0001));
        dir_typed.push_back(1); dir_exp.push_back(ack(6'd0));
        dir_tab.push_back(ctl_item(KIND_RENDER, 31'd0));
        dir_typed.push_back(0); dir_exp.push_back(ack(6'd0));

        foreach (dir_tab[i])
        begin
            send_item(dir_tab[i]);
            if (dir_typed[i])
                sprite_q[sprite_q.size() - 1] = dir_exp[i];
        end

        // Random traffic; pool wraps several times
        for (int i = 0; i < 285; i++)
        begin
            if (i == 140)
            begin
                // drain everything before going on
                cmd_if.valid = 1'b0;
                burst_left = 0;
                wait (sprite_q.size() == 0);
                @(negedge clk);
            end
            send_item(random_item());
        end
        cmd_if.valid = 1'b0;

        wait (sprite_q.size() == 0);
        repeat (100)
            @(posedge clk);
        $display("Ran %0d items (emit/tick/render/unused, ring wrap, saturation cases);",
                 n_items);
        $display("checked %0d results, %0d of them sprites, errors %0d.",
                 n_results, n_sprites, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/ppe_pkg.sv
sv/ppe_in_if.sv
sv/ppe_out_if.sv
sv/ppe_alu.sv
sv/ppe_store.sv
sv/particle_pool_engine_core.sv
sv/ppe_checker.sv
dv/tb.sv
